// ===== sv/palette_linear_fader_macros.svh =====
// ------------------------------------------------------------------------
// palette linear fader assertion macros
// shared concurrent assertion forms for the port checker
// ------------------------------------------------------------------------
`ifndef PALETTE_LINEAR_FADER_MACROS_SVH
`define PALETTE_LINEAR_FADER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pfd_pkg.sv =====
// ------------------------------------------------------------------------
// pfd_pkg
// types, constants and control structs of the palette linear fader
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfd_pkg;

	// field and storage widths
	localparam int CHANNELS_DEF = 384;
	localparam int OP_W         = 2;
	localparam int CH_W         = 9;
	localparam int LEVEL_W      = 16;
	localparam int ACC_W        = 17;
	localparam int COUNT_W      = 8;
	localparam int DIV_STEPS_W  = 4;

	// configuration registers
	localparam int           PADDR_W       = 3;
	localparam int           PDATA_W       = 32;
	localparam logic         REG_DIVISIONS = 1'b0;
	localparam logic         REG_LIMIT     = 1'b1;
	localparam logic [7:0]   DIVISIONS_RST = 8'd80;
	localparam logic [7:0]   LIMIT_RST     = 8'd80;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [CH_W-1:0]    channel_index;
		logic [LEVEL_W-1:0] start_level;
		logic [LEVEL_W-1:0] end_level;
	} item_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] channel_level;
		logic [COUNT_W-1:0] steps_taken;
		logic               fade_finished;
	} item_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIVIDE,
		ST_LOAD_WRITE,
		ST_ADVANCE,
		ST_DRAIN,
		ST_RESPOND
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic div_step;
		logic load_write;
		logic count_inc;
		logic walk_start;
		logic walk_read;
		logic chan_read;
		logic respond;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic can_advance;
		logic div_last;
		logic walk_last;
	} status_t;

endpackage

// ===== sv/palette_linear_fader.sv =====
// a load runs a radix-2 divider before writing the level rams; an advance walks every
// channel, one ram entry per cycle; an advance at the step limit skips the walk
// and only reports; next command accepted in the strobe cycle
// one command at a time; the result strobe lasts one cycle and cannot be stalled
// reset: step count 0, fade_divisions and step_limit 80, level rams not cleared
// ------------------------------------------------------------------------
// palette_linear_fader
// linear palette fade engine with apb register port
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_linear_fader
	import pfd_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  item_in_t           item,
	output logic               done,
	output item_out_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [7:0] divisions_q;
	logic [7:0] limit_q;
	cmd_t       cmd;
	status_t    status;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisions_q <= DIVISIONS_RST;
			limit_q     <= LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_DIVISIONS) begin
				divisions_q <= pwdata[7:0];
			end else begin
				limit_q <= pwdata[7:0];
			end
		end
	end

	// register reads
	assign prdata = {24'd0, (paddr[2] == REG_LIMIT) ? limit_q : divisions_q};
	assign pready = 1'b1;

	pfd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	pfd_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.item           (item),
		.fade_divisions (divisions_q),
		.step_limit     (limit_q),
		.result         (result),
		.done           (done)
	);

endmodule

// ===== sv/pfd_ram.sv =====
// ------------------------------------------------------------------------
// pfd_ram
// simple dual-port ram, one write port, one registered read port
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_ram #(
	parameter int WIDTH  = 17,
	parameter int DEPTH  = 384,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/pfd_ctrl.sv =====
// ------------------------------------------------------------------------
// pfd_ctrl
// sequencer for load, advance, read and no-op commands of the fader
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_ctrl
	import pfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (status.op)
					OP_LOAD: begin
						state_d = ST_DIVIDE;
					end
					OP_ADVANCE: begin
						if (status.can_advance) begin
							cmd.count_inc  = 1'b1;
							cmd.walk_start = 1'b1;
							state_d        = ST_ADVANCE;
						end else begin
							state_d = ST_RESPOND;
						end
					end
					OP_READ: begin
						cmd.chan_read = 1'b1;
						state_d       = ST_RESPOND;
					end
					OP_NOP: begin
						state_d = ST_RESPOND;
					end
				endcase
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_LOAD_WRITE;
				end
			end
			ST_LOAD_WRITE: begin
				cmd.load_write = 1'b1;
				state_d        = ST_RESPOND;
			end
			ST_ADVANCE: begin
				cmd.walk_read = 1'b1;
				if (status.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESPOND;
			end
			ST_RESPOND: begin
				cmd.respond = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/pfd_dp.sv =====
// ------------------------------------------------------------------------
// pfd_dp
// fader datapath: divider, level memories, channel walk, step count
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_dp
	import pfd_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output status_t      status,
	input  item_in_t     item,
	input  logic [7:0]   fade_divisions,
	input  logic [7:0]   step_limit,
	output item_out_t    result,
	output logic         done
);

	localparam int AW     = $clog2(CHANNELS);
	localparam int IT_W   = ACC_W + LEVEL_W;

	item_in_t            item_q;
	logic [7:0]          rem_q;
	logic [LEVEL_W-1:0]  quo_q;
	logic [DIV_STEPS_W-1:0] div_cnt_q;
	logic                neg_q;
	logic [COUNT_W-1:0]  count_q;
	logic                snap_q;
	logic [AW-1:0]       rd_idx_q;
	logic                wr_pend_s1;
	logic [AW-1:0]       wr_idx_s1;
	item_out_t           result_q;
	logic                done_q;

	logic [7:0]          div_eff;
	logic [7:0]          limit;
	logic [ACC_W-1:0]    diff;
	logic [ACC_W-1:0]    diff_abs;
	logic [8:0]          trial;
	logic                trial_ge;
	logic [ACC_W-1:0]    increment;
	logic                ch_valid;
	logic [AW-1:0]       ch_addr;

	logic                cur_we, cur_re, it_we;
	logic [AW-1:0]       cur_waddr, cur_raddr;
	logic [ACC_W-1:0]    cur_wdata, cur_rdata;
	logic [IT_W-1:0]     it_wdata, it_rdata;
	logic [ACC_W-1:0]    walk_inc;
	logic [LEVEL_W-1:0]  walk_tgt;

	// effective divisions and clamped step limit
	assign div_eff = (fade_divisions == 8'd0) ? 8'd1 : fade_divisions;
	assign limit   = (step_limit > div_eff) ? div_eff : step_limit;

	// channel decode
	assign ch_valid = 32'(item_q.channel_index) < CHANNELS;
	assign ch_addr  = AW'(item_q.channel_index);

	// signed span of the incoming load
	assign diff     = {1'b0, item.end_level} - {1'b0, item.start_level};
	assign diff_abs = diff[ACC_W-1] ? (ACC_W'(0) - diff) : diff;

	// one restoring division step
	assign trial    = {rem_q, quo_q[LEVEL_W-1]};
	assign trial_ge = trial >= {1'b0, div_eff};

	// quotient with sign restored, truncated toward zero
	assign increment = neg_q ? (ACC_W'(0) - {1'b0, quo_q}) : {1'b0, quo_q};

	// capture and divider
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			neg_q  <= diff[ACC_W-1];
			quo_q  <= diff_abs[LEVEL_W-1:0];
			rem_q  <= 8'd0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[LEVEL_W-2:0], trial_ge};
			rem_q <= trial_ge ? 8'(trial - {1'b0, div_eff}) : trial[7:0];
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.capture) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// step count and snap decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			snap_q  <= 1'b0;
		end else if (cmd.load_write) begin
			count_q <= '0;
		end else if (cmd.count_inc) begin
			count_q <= count_q + 1'b1;
			snap_q  <= ((count_q + 1'b1) == limit) && (limit == div_eff);
		end
	end

	// channel walk: read one entry a cycle, write it back after the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.walk_read;
			if (cmd.walk_start) begin
				rd_idx_q <= '0;
			end else if (cmd.walk_read) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_idx_s1 <= rd_idx_q;
	end

	// memory port selection
	assign walk_inc  = it_rdata[IT_W-1:LEVEL_W];
	assign walk_tgt  = it_rdata[LEVEL_W-1:0];
	assign cur_re    = cmd.walk_read | cmd.chan_read;
	assign cur_raddr = cmd.walk_read ? rd_idx_q : ch_addr;
	assign cur_we    = (cmd.load_write & ch_valid) | wr_pend_s1;
	assign cur_waddr = wr_pend_s1 ? wr_idx_s1 : ch_addr;
	assign cur_wdata = wr_pend_s1 ?
		(snap_q ? {1'b0, walk_tgt} : cur_rdata + walk_inc) :
		{1'b0, item_q.start_level};
	assign it_we     = cmd.load_write & ch_valid;
	assign it_wdata  = {increment, item_q.end_level};

	pfd_ram #(
		.WIDTH (ACC_W),
		.DEPTH (CHANNELS)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.re    (cur_re),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	pfd_ram #(
		.WIDTH (IT_W),
		.DEPTH (CHANNELS)
	) u_it_ram (
		.clk   (clk),
		.we    (it_we),
		.waddr (ch_addr),
		.wdata (it_wdata),
		.re    (cmd.walk_read),
		.raddr (rd_idx_q),
		.rdata (it_rdata)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			result_q.channel_level <= (item_q.operation == OP_READ && ch_valid) ?
				cur_rdata[LEVEL_W-1:0] : '0;
			result_q.steps_taken   <= count_q;
			result_q.fade_finished <= count_q >= limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	// status to controller
	assign status.op          = item_q.operation;
	assign status.can_advance = count_q < limit;
	assign status.div_last    = div_cnt_q == DIV_STEPS_W'(LEVEL_W - 1);
	assign status.walk_last   = rd_idx_q == AW'(CHANNELS - 1);

	assign result = result_q;
	assign done   = done_q;

endmodule

// ===== sv/pfd_checker.sv =====
// ------------------------------------------------------------------------
// pfd_checker
// port-level checks of command and result sequencing
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_linear_fader_macros.svh"

module pfd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// result only shows once the block is free again
	`PFD_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "result while busy")
	// an accepted transfer makes the block busy
	`PFD_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "not busy after accept")
	// one strobe per result
	`PFD_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe too long")
	// no result right after an accepted transfer
	`PFD_ASSERT_NEXT(a_accept_nodone, clk, arst_n, start && !busy, !done, "early result")

endmodule

bind palette_linear_fader pfd_checker u_pfd_checker (.*);
